// ----- sv/spf_sieve_factorizer_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sieve factorizer.
// ---------------------------------------------------------------------------
`ifndef SPF_SIEVE_FACTORIZER_MACROS_SVH
`define SPF_SIEVE_FACTORIZER_MACROS_SVH

// Checked only outside reset.
`define SPF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SPF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/spf_pkg.sv -----
// ---------------------------------------------------------------------------
// Sieve factorizer package
// Shared payload types, result codes and controller/datapath interface.
// ---------------------------------------------------------------------------
package spf_pkg;

  // Most results one query can produce.
  localparam int MAX_RESULTS = 8;
  // Quotient bits the divider produces, one per cycle.
  localparam int DIV_STEPS   = 16;

  typedef enum logic [2:0] {
    ST_FACTOR      = 3'd0,
    ST_BUILD_DONE  = 3'd1,
    ST_NO_FACTORS  = 3'd2,
    ST_ABOVE_LIMIT = 3'd3,
    ST_NOT_BUILT   = 3'd4
  } status_e;

  typedef enum logic {
    REQ_BUILD  = 1'b0,
    REQ_FACTOR = 1'b1
  } req_type_e;

  typedef struct packed {
    logic        req_type;
    logic [15:0] query_value;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] prime_factor;
    logic [4:0]  exponent;
    logic        last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_req;
    logic    clr_start;
    logic    clr_step;
    logic    sv_rd;
    logic    sv_mark;
    logic    k_rd;
    logic    mul;
    logic    sv_wr;
    logic    i_next;
    logic    q_rd;
    logic    q_pick;
    logic    div_start;
    logic    eval;
    logic    emit;
    status_e emit_code;
    logic    set_ready;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_build;
    logic ready;
    logic n_lt2;
    logic n_gt_lim;
    logic lim_lt2;
    logic clr_done;
    logic k_lt_cnt;
    logic stop_inner;
    logic i_at_lim;
    logic div_done;
    logic rem_zero;
    logic e_zero;
    logic fac_last;
  } sts_t;

endpackage

// ----- sv/spf_datapath.sv -----
// ---------------------------------------------------------------------------
// Sieve factorizer datapath
// Factor table, prime list, sieve counters, multiplier, serial divider
// and the result register.
// ---------------------------------------------------------------------------
module spf_datapath #(
  parameter int TABLE_SIZE       = 65536,
  parameter int PRIME_LIST_DEPTH = 8192
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spf_pkg::req_t req_i,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i,
  input  spf_pkg::cmd_t cmd_i,
  output spf_pkg::sts_t sts_o,
  output logic          res_valid_o,
  output spf_pkg::res_t res_o
);
  import spf_pkg::*;

  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int PAW = $clog2(PRIME_LIST_DEPTH);
  localparam int PCW = $clog2(PRIME_LIST_DEPTH + 1);
  localparam logic [15:0] LIM_CAP =
    16'((TABLE_SIZE - 1 > 65535) ? 65535 : TABLE_SIZE - 1);
  localparam logic [PCW-1:0] PL_FULL = PCW'(PRIME_LIST_DEPTH);

  logic [15:0]    ft_mem [TABLE_SIZE];
  logic [15:0]    pl_mem [PRIME_LIST_DEPTH];

  logic [15:0]    limit_q, lim;
  logic           ready_q;
  logic           req_build_q;
  logic [AW-1:0]  clr_q;
  logic [15:0]    i_q, fi_q, p_q, n_q;
  logic [PCW-1:0] pcnt_q, k_q;
  logic [31:0]    prod_q;
  logic [4:0]     e_q;
  logic [2:0]     cnt_q;
  logic [15:0]    ft_rdata_q, pl_rdata_q;
  logic [15:0]    dq_q, rr_q;
  logic [4:0]     dcnt_q;
  logic           dbusy_q, ddone_q;
  logic           res_valid_q;
  res_t           res_q;

  logic           ft_we, ft_re;
  logic [AW-1:0]  ft_waddr, ft_raddr;
  logic [15:0]    ft_wdata;
  logic           pl_we;
  logic           fi_zero;
  logic [16:0]    rr_sh;
  logic           div_ge;
  logic [15:0]    rr_next;
  logic           fac_last;

  assign cfg_ready_o = 1'b1;
  assign lim         = (limit_q > LIM_CAP) ? LIM_CAP : limit_q;
  assign fi_zero     = (ft_rdata_q == 16'd0);
  assign fac_last    = (n_q == 16'd1) || (cnt_q == 3'(MAX_RESULTS - 1));

  // Configuration register and built mark.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 16'hFFFF;
      ready_q <= 1'b0;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
      ready_q <= 1'b0;
    end else if (cmd_i.set_ready) begin
      ready_q <= 1'b1;
    end
  end

  // Factor table port selection.
  always_comb begin
    ft_we    = 1'b0;
    ft_waddr = clr_q;
    ft_wdata = 16'd0;
    if (cmd_i.clr_step) begin
      ft_we = 1'b1;
    end else if (cmd_i.sv_mark && fi_zero) begin
      ft_we    = 1'b1;
      ft_waddr = AW'(i_q);
      ft_wdata = i_q;
    end else if (cmd_i.sv_wr) begin
      ft_we    = 1'b1;
      ft_waddr = AW'(prod_q);
      ft_wdata = p_q;
    end
    ft_re    = cmd_i.sv_rd || cmd_i.q_rd;
    ft_raddr = cmd_i.q_rd ? AW'(n_q) : AW'(i_q);
  end

  assign pl_we = cmd_i.sv_mark && fi_zero && (pcnt_q < PL_FULL);

  // Factor table memory.
  always_ff @(posedge clk_i) begin
    if (ft_we) begin
      ft_mem[ft_waddr] <= ft_wdata;
    end
    if (ft_re) begin
      ft_rdata_q <= ft_mem[ft_raddr];
    end
  end

  // Prime list memory.
  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      pl_mem[pcnt_q[PAW-1:0]] <= i_q;
    end
    if (cmd_i.k_rd) begin
      pl_rdata_q <= pl_mem[k_q[PAW-1:0]];
    end
  end

  // Sieve control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      pcnt_q <= '0;
      k_q    <= '0;
      i_q    <= 16'd2;
    end else begin
      if (cmd_i.clr_start) begin
        clr_q  <= '0;
        pcnt_q <= '0;
        i_q    <= 16'd2;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (pl_we) begin
        pcnt_q <= pcnt_q + PCW'(1);
      end
      if (cmd_i.sv_mark) begin
        k_q <= '0;
      end else if (cmd_i.sv_wr) begin
        k_q <= k_q + PCW'(1);
      end
      if (cmd_i.i_next) begin
        i_q <= i_q + 16'd1;
      end
    end
  end

  // Sieve and query working values.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_build_q <= (req_i.req_type == REQ_BUILD);
      n_q         <= req_i.query_value;
      cnt_q       <= '0;
    end
    if (cmd_i.sv_mark) begin
      fi_q <= fi_zero ? i_q : ft_rdata_q;
    end
    if (cmd_i.mul) begin
      p_q    <= pl_rdata_q;
      prod_q <= pl_rdata_q * i_q;
    end
    if (cmd_i.q_pick) begin
      p_q <= (ft_rdata_q < 16'd2) ? n_q : ft_rdata_q;
      e_q <= '0;
    end
    if (cmd_i.eval) begin
      if (rr_q == 16'd0) begin
        n_q <= dq_q;
        e_q <= e_q + 5'd1;
      end else begin
        p_q <= n_q;
      end
    end
    if (cmd_i.emit && cmd_i.emit_code == ST_FACTOR) begin
      cnt_q <= cnt_q + 3'd1;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign rr_sh   = {rr_q, dq_q[15]};
  assign div_ge  = (rr_sh >= {1'b0, p_q});
  assign rr_next = div_ge ? 16'(rr_sh - {1'b0, p_q}) : rr_sh[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      dbusy_q <= 1'b1;
      ddone_q <= 1'b0;
      dcnt_q  <= 5'(DIV_STEPS);
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - 5'd1;
      if (dcnt_q == 5'd1) begin
        dbusy_q <= 1'b0;
        ddone_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q <= n_q;
      rr_q <= 16'd0;
    end else if (dbusy_q) begin
      dq_q <= {dq_q[14:0], div_ge};
      rr_q <= rr_next;
    end
  end

  // Result register, shown for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.status <= cmd_i.emit_code;
      if (cmd_i.emit_code == ST_FACTOR) begin
        res_q.prime_factor <= p_q;
        res_q.exponent     <= e_q;
        res_q.last         <= fac_last;
      end else begin
        res_q.prime_factor <= 16'd0;
        res_q.exponent     <= 5'd0;
        res_q.last         <= 1'b1;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Status toward the controller.
  always_comb begin
    sts_o.req_build  = req_build_q;
    sts_o.ready      = ready_q;
    sts_o.n_lt2      = (n_q < 16'd2);
    sts_o.n_gt_lim   = (n_q > lim);
    sts_o.lim_lt2    = (lim < 16'd2);
    sts_o.clr_done   = (clr_q == '1);
    sts_o.k_lt_cnt   = (k_q < pcnt_q);
    sts_o.stop_inner = (p_q > fi_q) || (prod_q > {16'd0, lim});
    sts_o.i_at_lim   = (i_q == lim);
    sts_o.div_done   = ddone_q;
    sts_o.rem_zero   = (rr_q == 16'd0);
    sts_o.e_zero     = (e_q == 5'd0);
    sts_o.fac_last   = fac_last;
  end

endmodule

// ----- sv/spf_ctrl.sv -----
// ---------------------------------------------------------------------------
// Sieve factorizer controller
// Sequences clearing, sieving and factorization over the datapath.
// ---------------------------------------------------------------------------
module spf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spf_pkg::sts_t sts_i,
  output spf_pkg::cmd_t cmd_o
);
  import spf_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DISP   = 14'b00000000000010,
    S_CLEAR  = 14'b00000000000100,
    S_SV_RD  = 14'b00000000001000,
    S_SV_CHK = 14'b00000000010000,
    S_SV_PRD = 14'b00000000100000,
    S_SV_MUL = 14'b00000001000000,
    S_SV_WR  = 14'b00000010000000,
    S_SV_NXT = 14'b00000100000000,
    S_Q_RD   = 14'b00001000000000,
    S_Q_PICK = 14'b00010000000000,
    S_D_GO   = 14'b00100000000000,
    S_D_WAIT = 14'b01000000000000,
    S_D_EVAL = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.req_build) begin
          cmd_o.clr_start = 1'b1;
          state_d         = S_CLEAR;
        end else if (!sts_i.ready) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_code = ST_NOT_BUILT;
          state_d         = S_IDLE;
        end else if (sts_i.n_lt2) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_code = ST_NO_FACTORS;
          state_d         = S_IDLE;
        end else if (sts_i.n_gt_lim) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_code = ST_ABOVE_LIMIT;
          state_d         = S_IDLE;
        end else begin
          state_d = S_Q_RD;
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          if (sts_i.lim_lt2) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_code = ST_BUILD_DONE;
            cmd_o.set_ready = 1'b1;
            state_d         = S_IDLE;
          end else begin
            state_d = S_SV_RD;
          end
        end
      end
      S_SV_RD: begin
        cmd_o.sv_rd = 1'b1;
        state_d     = S_SV_CHK;
      end
      S_SV_CHK: begin
        cmd_o.sv_mark = 1'b1;
        state_d       = S_SV_PRD;
      end
      S_SV_PRD: begin
        if (sts_i.k_lt_cnt) begin
          cmd_o.k_rd = 1'b1;
          state_d    = S_SV_MUL;
        end else begin
          state_d = S_SV_NXT;
        end
      end
      S_SV_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SV_WR;
      end
      S_SV_WR: begin
        if (sts_i.stop_inner) begin
          state_d = S_SV_NXT;
        end else begin
          cmd_o.sv_wr = 1'b1;
          state_d     = S_SV_PRD;
        end
      end
      S_SV_NXT: begin
        if (sts_i.i_at_lim) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_code = ST_BUILD_DONE;
          cmd_o.set_ready = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.i_next = 1'b1;
          state_d      = S_SV_RD;
        end
      end
      S_Q_RD: begin
        cmd_o.q_rd = 1'b1;
        state_d    = S_Q_PICK;
      end
      S_Q_PICK: begin
        cmd_o.q_pick = 1'b1;
        state_d      = S_D_GO;
      end
      S_D_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_D_WAIT;
      end
      S_D_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_D_EVAL;
        end
      end
      S_D_EVAL: begin
        // Keep dividing while the prime divides, or retry with the value itself.
        if (sts_i.rem_zero || sts_i.e_zero) begin
          cmd_o.eval = 1'b1;
          state_d    = S_D_GO;
        end else begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_code = ST_FACTOR;
          state_d         = sts_i.fac_last ? S_IDLE : S_Q_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/spf_sieve_factorizer.sv -----
// Build: a clearing sweep over the whole table, then a sieve pass that writes the
//   smallest prime factor of each entry up to the limit; one build-done beat follows.
// Query: one status beat for a rejected request; otherwise a table lookup and
//   divisions on the serial divider for each prime, one beat per prime.
// One request at a time; busy stays high until its last beat is issued.
// Reset: asynchronous, active low; the table must be built before a query.
// ---------------------------------------------------------------------------
// Sieve factorizer top level
// Smallest-prime-factor sieve with query factorization.
// ---------------------------------------------------------------------------
`include "spf_sieve_factorizer_macros.svh"

module spf_sieve_factorizer #(
  parameter int TABLE_SIZE       = 65536,
  parameter int PRIME_LIST_DEPTH = 8192
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spf_pkg::req_t req_i,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i,
  output logic          res_valid_o,
  output spf_pkg::res_t res_o
);
  import spf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  spf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Storage and arithmetic.
  spf_datapath #(
    .TABLE_SIZE       (TABLE_SIZE),
    .PRIME_LIST_DEPTH (PRIME_LIST_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Checks.
  `SPF_ASSERT(a_start_busy, start && !busy |=> busy, "accepted request did not raise busy")
  `SPF_ASSERT(a_factor_beat, res_valid_o && res_o.status == ST_FACTOR |-> res_o.prime_factor >= 16'd2 && res_o.exponent != 5'd0, "factor beat with bad prime or exponent")
  `SPF_ASSERT(a_single_beat, res_valid_o && res_o.status != ST_FACTOR |-> res_o.prime_factor == 16'd0 && res_o.exponent == 5'd0 && res_o.last, "status beat with stray fields")
  `SPF_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !res_valid_o && !busy, "activity during reset")

endmodule

// ----- sim/tb_spf_sieve_factorizer.sv -----
// ---------------------------------------------------------------------------
// Sieve factorizer testbench
// Builds the smallest-prime-factor table at several limits, including the
// largest and the smallest. It sends directed and random queries, predicts
// every result beat and compares each beat field by field as it arrives.
// ---------------------------------------------------------------------------
module tb_spf_sieve_factorizer;
  import spf_pkg::*;

  localparam int TBL_SIZE    = 65536;
  localparam int PLIST_DEPTH = 8192;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int DRAIN_CYCLES = 64;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        res_valid_o;
  res_t        res_o;

  // Predictor state.
  bit [15:0] spf_table [TBL_SIZE];
  bit [15:0] primes [PLIST_DEPTH];
  int        num_primes;
  bit        table_built;
  bit [15:0] limit_reg;

  res_t      pending_beats [$];
  int        num_errors;
  int        cycle_count;
  int        sender_idle_pct;

  spf_sieve_factorizer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run the linear sieve over 2..limit.
  task automatic sieve_build();
    int lim;
    int i;
    int k;
    int p;
    lim = limit_reg;
    if (lim > TBL_SIZE - 1) lim = TBL_SIZE - 1;
    for (i = 0; i < TBL_SIZE; i++) spf_table[i] = '0;
    num_primes = 0;
    for (i = 2; i <= lim; i++) begin
      if (spf_table[i] == 0) begin
        spf_table[i] = i[15:0];
        if (num_primes < PLIST_DEPTH) begin
          primes[num_primes] = i[15:0];
          num_primes++;
        end
      end
      for (k = 0; k < num_primes; k++) begin
        p = primes[k];
        if (p > spf_table[i] || p * i > lim) break;
        spf_table[p * i] = p[15:0];
      end
    end
    table_built = 1'b1;
  endtask

  // Queue one single-beat reply carrying only a status code.
  task automatic push_status(status_e code);
    res_t r;
    r.status       = code;
    r.prime_factor = '0;
    r.exponent     = '0;
    r.last         = 1'b1;
    pending_beats.insert(pending_beats.size(), r);
  endtask

  // Work out the beats that one accepted request produces.
  task automatic predict_factors(req_t rq);
    int n;
    int p;
    int e;
    int cnt;
    res_t r;
    n = rq.query_value;
    cnt = 0;
    if (rq.req_type == REQ_BUILD) begin
      sieve_build();
      push_status(ST_BUILD_DONE);
    end else if (!table_built) begin
      push_status(ST_NOT_BUILT);
    end else if (n < 2) begin
      push_status(ST_NO_FACTORS);
    end else if (n > limit_reg) begin
      push_status(ST_ABOVE_LIMIT);
    end else begin
      while (n > 1 && cnt < MAX_RESULTS) begin
        p = spf_table[n];
        e = 0;
        if (p < 2 || (n % p) != 0) p = n;
        while (n % p == 0) begin
          n = n / p;
          e++;
        end
        cnt++;
        r.status       = ST_FACTOR;
        r.prime_factor = p[15:0];
        r.exponent     = e[4:0];
        r.last         = (n <= 1 || cnt == MAX_RESULTS);
        pending_beats.insert(pending_beats.size(), r);
      end
    end
  endtask

  // Print one mismatch line and count it.
  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    num_errors++;
  endtask

  // Send one request beat after a random gap; returns once it is accepted.
  task automatic send_request(bit rtype, bit [15:0] value);
    req_t rq;
    rq.req_type    = rtype;
    rq.query_value = value;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    req_i <= rq;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_factors(rq);
  endtask

  // Stop sending and wait until every predicted beat has arrived.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the limit register while the block is idle.
  task automatic write_limit(bit [15:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    limit_reg   = value;
    table_built = 1'b0;
  endtask

  // Result checker: each beat against the oldest expectation.
  always @(posedge clk_i) begin
    res_t exp_beat;
    if (rst_ni && res_valid_o) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        exp_beat = pending_beats.pop_front();
        if (res_o.status !== exp_beat.status)
          report_mismatch($sformatf("status %0d, expected %0d", res_o.status,
                                    exp_beat.status));
        if (res_o.prime_factor !== exp_beat.prime_factor)
          report_mismatch($sformatf("prime %0d, expected %0d", res_o.prime_factor,
                                    exp_beat.prime_factor));
        if (res_o.exponent !== exp_beat.exponent)
          report_mismatch($sformatf("exponent %0d, expected %0d", res_o.exponent,
                                    exp_beat.exponent));
        if (res_o.last !== exp_beat.last)
          report_mismatch($sformatf("last %0b, expected %0b", res_o.last,
                                    exp_beat.last));
      end
    end
  end

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Queries before any build, then the full table with edge values.
  task automatic test_full_table();
    send_request(REQ_FACTOR, 16'd12);
    send_request(REQ_BUILD, 16'hFFFF);
    send_request(REQ_FACTOR, 16'd0);
    send_request(REQ_FACTOR, 16'd1);
    send_request(REQ_FACTOR, 16'd2);
    send_request(REQ_FACTOR, 16'hFFFF);
    send_request(REQ_FACTOR, 16'd65521);
    send_request(REQ_FACTOR, 16'd32768);
    send_request(REQ_FACTOR, 16'd30030);
    send_request(REQ_FACTOR, 16'd60060);
    send_request(REQ_FACTOR, 16'd65535 - 16'd1);
    send_request(REQ_FACTOR, 16'd4);
  endtask

  // Smallest legal limit, then a limit below two.
  task automatic test_small_limits();
    write_limit(16'd2);
    send_request(REQ_FACTOR, 16'd2);
    send_request(REQ_BUILD, 16'd0);
    send_request(REQ_FACTOR, 16'd2);
    send_request(REQ_FACTOR, 16'd3);
    send_request(REQ_FACTOR, 16'd1);
    write_limit(16'd0);
    send_request(REQ_FACTOR, 16'd0);
    send_request(REQ_BUILD, 16'hFFFF);
    send_request(REQ_FACTOR, 16'd2);
    send_request(REQ_FACTOR, 16'd1);
  endtask

  // Random limits and queries under each idling pattern.
  task automatic test_random_queries();
    int ph;
    int j;
    int lim;
    int sel;
    bit [15:0] q;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 51;
        2: sender_idle_pct = 0;
        default: sender_idle_pct = 12;
      endcase
      lim = $urandom_range(3000, 2);
      write_limit(lim[15:0]);
      send_request(REQ_FACTOR, 16'($urandom_range(65535)));
      send_request(REQ_BUILD, 16'($urandom_range(65535)));
      for (j = 0; j < 30; j++) begin
        sel = $urandom_range(99);
        if (sel < 80) q = 16'($urandom_range(lim, 2));
        else if (sel < 90) q = 16'($urandom_range(65535, lim + 1));
        else q = 16'($urandom_range(1));
        send_request(REQ_FACTOR, q);
      end
    end
  endtask

  // Main sequence.
  initial begin
    start           <= 1'b0;
    req_i           <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    cycle_count     = 0;
    num_errors      = 0;
    sender_idle_pct = 0;
    limit_reg       = 16'hFFFF;
    table_built     = 1'b0;
    num_primes      = 0;
    rst_ni          = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_table();
    test_small_limits();
    test_random_queries();
    wait_drained();

    if (num_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
